### design/qle_pkg.sv
// Shared types, field widths and table geometry of the Q-learning engine.
package qle_pkg;

    // Table geometry
    localparam int NUM_CELLS   = 9;
    localparam int NUM_ACTIONS = 8;
    localparam int NUM_LEVELS  = 3;

    // Field widths
    localparam int OP_W      = 2;
    localparam int LEVELS_W  = 18;
    localparam int ACTION_W  = 3;
    localparam int QUALITY_W = 13;
    localparam int VALUE_W   = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    function automatic int ipow(input int base, input int expo);
        int acc;
        acc = 1;
        for (int i = 0; i < expo; i++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    localparam int STATE_COUNT = ipow(NUM_LEVELS, NUM_CELLS);
    localparam int DEPTH       = STATE_COUNT * NUM_ACTIONS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int ROW_W       = $clog2(STATE_COUNT);
    localparam int ACT_W       = (NUM_ACTIONS > 2) ? $clog2(NUM_ACTIONS) : 1;
    localparam int IDX_W       = $clog2(NUM_ACTIONS + 1);

    localparam logic [1:0] LEVEL_MAX = 2'(NUM_LEVELS - 1);

    typedef logic        [OP_W-1:0]      t_op;
    typedef logic        [LEVELS_W-1:0]  t_levels;
    typedef logic        [ACTION_W-1:0]  t_action;
    typedef logic        [QUALITY_W-1:0] t_quality;
    typedef logic signed [VALUE_W-1:0]   t_value;

    // Operation codes
    localparam t_op OP_SELECT = 2'd0;
    localparam t_op OP_UPDATE = 2'd1;
    localparam t_op OP_WRITE  = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    // Base-NUM_LEVELS state index, cell 0 least significant, levels clamped
    function automatic logic [ROW_W-1:0] state_index(input t_levels levels);
        t_levels          sh;
        logic [1:0]       lv;
        int unsigned      w;
        logic [ROW_W-1:0] idx;
        idx = '0;
        w   = 1;
        for (int i = 0; i < NUM_CELLS; i++) begin
            sh = levels >> (2 * i);
            lv = sh[1:0];
            if (lv > LEVEL_MAX) lv = LEVEL_MAX;
            idx = idx + ROW_W'(lv * w);
            w   = w * NUM_LEVELS;
        end
        return idx;
    endfunction

    // First table address of a state's row
    function automatic logic [ADDR_W-1:0] row_base(input t_levels levels);
        return ADDR_W'(state_index(levels)) * ADDR_W'(NUM_ACTIONS);
    endfunction

    // Column of an action: action modulo NUM_ACTIONS on a narrow value
    function automatic logic [ACT_W-1:0] col_of(input t_action act);
        t_action v;
        v = act;
        for (int i = 0; i < 4; i++) begin
            if (v >= NUM_ACTIONS) v = v - ACTION_W'(NUM_ACTIONS);
        end
        return ACT_W'(v);
    endfunction

endpackage

### design/qle_in_if.sv
// Request channel: one input word per handshake.
interface qle_in_if;
    import qle_pkg::*;

    logic     valid;
    logic     ready;
    t_op      op;
    t_levels  state_levels;
    t_levels  next_levels;
    t_action  action;
    t_quality quality;
    t_value   entry_value;

    modport source (
        output valid, op, state_levels, next_levels, action, quality, entry_value,
        input  ready
    );

    modport sink (
        input  valid, op, state_levels, next_levels, action, quality, entry_value,
        output ready
    );
endinterface

### design/qle_out_if.sv
// Response channel: one result word per handshake.
interface qle_out_if;
    import qle_pkg::*;

    logic    valid;
    logic    ready;
    t_action chosen_action;
    t_value  value;

    modport source (
        output valid, chosen_action, value,
        input  ready
    );

    modport sink (
        input  valid, chosen_action, value,
        output ready
    );
endinterface

### design/tabular_q_learning_engine.sv
// Tabular Q-learning engine: Q table memory, greedy row search and one-step update.
//
// Usage: requests arrive on i_req (valid/ready), one result word per request leaves on
// o_rsp (valid/ready). Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data.
// The Q table is one single-port-write, one-read memory of NUM_LEVELS^NUM_CELLS *
// NUM_ACTIONS words, with a registered read. One request is worked at a time.
// Steps of each request after it is accepted:
//   select  row search, reading one word a cycle from the memory
//   update  row search, entry read, two multiplies, write-back
//   write   one table write, read   one table read
// The result word is registered; for select it is loaded once the row search is done,
// and for update once the row search, the entry read with the two dependent
// multiplies and the write-back are done.
// Reset: registers take their defaults and a clearing pass writes zero to every table
// word, one per cycle; no request is taken meanwhile, though register writes are
// accepted.
// Stall: a result waits in the output register while o_rsp.ready is low; the next
// request is accepted meanwhile and held before its own result until the register frees.
module tabular_q_learning_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    qle_in_if.sink                        i_req,
    qle_out_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [qle_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qle_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qle_pkg::*;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY   = 3'd4;

    // Sequencer states
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INDEX   = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_QREAD   = 4'd4;
    localparam logic [3:0] S_QWAIT   = 4'd5;
    localparam logic [3:0] S_DELTA   = 4'd6;
    localparam logic [3:0] S_MUL2    = 4'd7;
    localparam logic [3:0] S_WB      = 4'd8;
    localparam logic [3:0] S_WRITE   = 4'd9;
    localparam logic [3:0] S_RDISSUE = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    // Divide by ten through a reciprocal: floor(x * M / 2^26) for x below 2^21
    localparam int MAG_W   = 21;
    localparam int RECIP_W = 23;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int RECIP_S = 26;
    localparam logic [RECIP_W-1:0] RECIP_M = 23'd6710887;
    localparam logic [MAG_W-1:0]   MAG_HALF = 21'd5;

    localparam logic signed [28:0] NEW_MAX = 29'sd8388607;
    localparam logic signed [28:0] NEW_MIN = -29'sd8388608;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 24'sd8388607;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = -24'sd8388608;

    // Configuration registers
    logic [QUALITY_W-1:0] r_thr;
    logic [15:0]          r_lr;
    logic [15:0]          r_disc;
    t_value               r_succ;
    logic [22:0]          r_pen;

    // Sequencer
    logic [3:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pend_idx;
    logic              r_out_valid;

    // Request word
    t_op      r_op;
    t_levels  r_lv_s, r_lv_n;
    t_action  r_act;
    t_quality r_qual;
    t_value   r_entry;

    // Datapath
    logic [ADDR_W-1:0]  r_slot, r_scan_base;
    logic               r_success;
    logic [MAG_W-1:0]   r_mag5;
    logic [PROD_W-1:0]  r_recip;
    t_value             r_max;
    logic [ACT_W-1:0]   r_best;
    logic signed [24:0] r_reward;
    logic signed [40:0] r_gprod;
    logic signed [25:0] r_target;
    logic signed [26:0] r_delta;
    logic signed [43:0] r_aprod;
    t_value             r_newq;
    t_action            r_out_action;
    t_value             r_out_value;

    // Memory
    t_value            r_mem [DEPTH];
    t_value            r_rdata;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    t_value            mem_wdata;

    logic              in_ready, out_load;
    logic              clr_last;
    logic [QUALITY_W-1:0] thr_diff;
    logic [RECIP_W-6:0]   quot10;
    logic signed [24:0] reward_fail, reward_ok;
    logic signed [40:0] g_sum;
    logic signed [24:0] g_rnd;
    logic signed [43:0] a_sum;
    logic signed [27:0] a_rnd;
    logic signed [28:0] new_full;
    t_value             newq;

    assign clr_last = (r_clr == ADDR_W'(DEPTH - 1));

    // Reward pieces
    assign thr_diff    = r_thr - r_qual;
    assign quot10      = r_recip[PROD_W-1:RECIP_S];
    assign reward_fail = 25'sd0 - $signed({7'd0, quot10}) - $signed({2'd0, r_pen});
    assign reward_ok   = {r_succ[VALUE_W-1], r_succ};

    // Rounded products, new entry value with saturation
    assign g_sum    = r_gprod + 41'sd32768;
    assign g_rnd    = g_sum[40:16];
    assign a_sum    = r_aprod + 44'sd32768;
    assign a_rnd    = a_sum[43:16];
    assign new_full = {{5{r_rdata[VALUE_W-1]}}, r_rdata} + {a_rnd[27], a_rnd};

    always_comb begin
        if (new_full > NEW_MAX) begin
            newq = VAL_MAX;
        end else if (new_full < NEW_MIN) begin
            newq = VAL_MIN;
        end else begin
            newq = new_full[VALUE_W-1:0];
        end
    end

    // Sequencer and memory port control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_slot;
        mem_raddr = r_slot;
        mem_wdata = r_entry;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) n_state = S_INDEX;
            end
            S_INDEX: begin
                case (r_op)
                    OP_SELECT: n_state = S_SCAN;
                    OP_UPDATE: n_state = S_SCAN;
                    OP_WRITE:  n_state = S_WRITE;
                    default:   n_state = S_RDISSUE;
                endcase
            end
            S_SCAN: begin
                if (r_idx < NUM_ACTIONS) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_scan_base + ADDR_W'(r_idx);
                end
                if (r_pend && r_pend_idx == IDX_W'(NUM_ACTIONS - 1)) begin
                    n_state = (r_op == OP_UPDATE) ? S_QREAD : S_DONE;
                end
            end
            S_QREAD: begin
                mem_re  = 1'b1;
                n_state = S_QWAIT;
            end
            S_QWAIT: n_state = S_DELTA;
            S_DELTA: n_state = S_MUL2;
            S_MUL2:  n_state = S_WB;
            S_WB: begin
                mem_we    = 1'b1;
                mem_wdata = newq;
                n_state   = S_DONE;
            end
            S_WRITE: begin
                mem_we  = 1'b1;
                n_state = S_DONE;
            end
            S_RDISSUE: begin
                mem_re  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.chosen_action = r_out_action;
    assign o_rsp.value         = r_out_value;

    // Q table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_INDEX) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN && r_idx < NUM_ACTIONS) begin
                r_idx <= r_idx + 1'b1;
            end
            r_pend     <= (r_state == S_SCAN) && (r_idx < NUM_ACTIONS);
            r_pend_idx <= r_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 13'd4400;
            r_lr   <= 16'd655;
            r_disc <= 16'd6554;
            r_succ <= 24'sd40960;
            r_pen  <= 23'd8192;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr  <= i_cfg_data[QUALITY_W-1:0];
                CFG_LEARN:     r_lr   <= i_cfg_data[15:0];
                CFG_DISCOUNT:  r_disc <= i_cfg_data[15:0];
                CFG_SUCCESS:   r_succ <= i_cfg_data[VALUE_W-1:0];
                CFG_PENALTY:   r_pen  <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // capture request word
        if (in_ready && i_req.valid) begin
            r_op    <= i_req.op;
            r_lv_s  <= i_req.state_levels;
            r_lv_n  <= i_req.next_levels;
            r_act   <= i_req.action;
            r_qual  <= i_req.quality;
            r_entry <= i_req.entry_value;
        end
        // addresses and reward magnitude
        if (r_state == S_INDEX) begin
            r_slot      <= row_base(r_lv_s) + ADDR_W'(col_of(r_act));
            r_scan_base <= (r_op == OP_UPDATE) ? row_base(r_lv_n) : row_base(r_lv_s);
            r_success   <= (r_qual >= r_thr);
            r_mag5      <= {thr_diff, 8'd0} + MAG_HALF;
        end
        r_recip <= r_mag5 * RECIP_M;
        // greedy search, lowest index keeps ties
        if (r_pend) begin
            if (r_pend_idx == '0 || r_rdata > r_max) begin
                r_max  <= r_rdata;
                r_best <= r_pend_idx[ACT_W-1:0];
            end
        end
        if (r_state == S_QREAD) begin
            r_reward <= r_success ? reward_ok : reward_fail;
            r_gprod  <= r_max * $signed({1'b0, r_disc});
        end
        if (r_state == S_QWAIT) begin
            r_target <= {r_reward[24], r_reward} + {g_rnd[24], g_rnd};
        end
        if (r_state == S_DELTA) begin
            r_delta <= {r_target[25], r_target} - {{3{r_rdata[VALUE_W-1]}}, r_rdata};
        end
        if (r_state == S_MUL2) begin
            r_aprod <= r_delta * $signed({1'b0, r_lr});
        end
        if (r_state == S_WB) r_newq <= newq;
        // result word
        if (out_load) begin
            case (r_op)
                OP_SELECT: begin
                    r_out_action <= ACTION_W'(r_best);
                    r_out_value  <= r_max;
                end
                OP_UPDATE: begin
                    r_out_action <= r_act;
                    r_out_value  <= r_newq;
                end
                OP_WRITE: begin
                    r_out_action <= r_act;
                    r_out_value  <= r_entry;
                end
                default: begin
                    r_out_action <= r_act;
                    r_out_value  <= r_rdata;
                end
            endcase
        end
    end

    // No table write may land while a row is being searched
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("table write during row search");

    // Result register is only loaded when its word has gone or is leaving
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("result word overwritten");

    // Pending read index stays inside the row
    a_pend_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pend_idx < NUM_ACTIONS))
        else $error("row search past last column");

    // An accepted request always starts with address formation
    a_accept_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_INDEX))
        else $error("accepted request not started");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the tabular Q-learning engine, with a mirror of the Q table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qle_pkg::*;

    // Run control
    localparam int WATCHDOG_LIMIT = 800000;   // must outlast the clearing pass after reset
    localparam int IDLE_PCT       = 36;
    localparam int HOLD_AT        = 300;      // receiver hold-off starts after this many words
    localparam int HOLD_CYCLES    = 400;
    localparam int PAUSE_AT       = 650;      // sender drains the engine after this many words
    localparam int PHASE_ITEMS    = 185;
    localparam int NUM_PHASES     = 5;
    localparam int POOL_SIZE      = 8;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_CYCLES    = 40;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUCCESS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY    = 3'd4;

    // Fixed-point helpers
    localparam int     FRAC_SHIFT   = 16;
    localparam longint ROUND_HALF   = longint'(1) << (FRAC_SHIFT - 1);
    localparam longint QUAL_TO_Q12  = 256;    // 4 fraction bits up to 12
    localparam longint TENTH_DIV    = 10;
    localparam longint TENTH_ROUND  = 5;
    localparam longint VAL_MAX      = (longint'(1) << (VALUE_W - 1)) - 1;
    localparam longint VAL_MIN      = -(longint'(1) << (VALUE_W - 1));
    localparam int     QUAL_MAX     = (1 << QUALITY_W) - 1;
    localparam int     ACTION_MAX   = (1 << ACTION_W) - 1;

    // Level patterns used by the directed words
    localparam t_levels LV_ZERO  = 18'h00000;
    localparam t_levels LV_ONES  = 18'h15555;
    localparam t_levels LV_TWOS  = 18'h2AAAA;
    localparam t_levels LV_THREE = 18'h3FFFF;
    localparam t_value  V_MAX    = 24'sh7FFFFF;
    localparam t_value  V_MIN    = 24'sh800000;

    typedef struct {
        t_op      op;
        t_levels  lv;
        t_levels  next_lv;
        t_action  act;
        t_quality qual;
        t_value   entry;
    } req_word_t;

    typedef struct {
        t_action act;
        t_value  value;
    } rsp_word_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qle_in_if  req_bus ();
    qle_out_if rsp_bus ();

    tabular_q_learning_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the table and the registers
    bit signed [VALUE_W-1:0] q_mirror [DEPTH];
    t_quality    thr_m   = 13'd4400;
    logic [15:0] alpha_m = 16'd655;
    logic [15:0] gamma_m = 16'd6554;
    t_value      win_m   = 24'sd40960;
    logic [22:0] pen_m   = 23'd8192;

    req_word_t req_words [$];     // words waiting to be offered
    rsp_word_t outcome_q [$];     // predicted result words, oldest first

    int      acc_total    = 0;
    int      idle_cycles  = 0;
    int      err_count    = 0;
    bit      in_fire      = 1'b0;
    bit      calm         = 1'b0;
    bit      pause_on     = 1'b0;
    bit      pause_done   = 1'b0;
    bit      hold_done    = 1'b0;
    int      hold_left    = 0;
    bit      timed_out;
    t_levels pool [POOL_SIZE];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Row number of a level pattern: base-NUM_LEVELS digits, cell 0 lowest, clamped
    function automatic int row_of(input t_levels levels);
        int         idx;
        int         w;
        logic [1:0] lv;
        idx = 0;
        w   = 1;
        for (int i = 0; i < NUM_CELLS; i++) begin
            lv = levels[2*i +: 2];
            if (int'(lv) > NUM_LEVELS - 1) lv = 2'(NUM_LEVELS - 1);
            idx = idx + int'(lv) * w;
            w   = w * NUM_LEVELS;
        end
        return idx;
    endfunction

    // Largest entry of a row; first index wins a tie
    function automatic longint row_peak(input int row, output int best);
        longint m;
        longint v;
        m    = q_mirror[row * NUM_ACTIONS];
        best = 0;
        for (int a = 1; a < NUM_ACTIONS; a++) begin
            v = q_mirror[row * NUM_ACTIONS + a];
            if (v > m) begin
                m    = v;
                best = a;
            end
        end
        return m;
    endfunction

    function automatic longint clip24(input longint v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    // Result word of one request; applies its effect to the mirror
    function automatic rsp_word_t qle_outcome(input req_word_t w);
        rsp_word_t r;
        int        row;
        int        slot;
        int        best;
        longint    thr;
        longint    qual;
        longint    reward;
        longint    nmax;
        longint    tgt;
        longint    cur;
        longint    delta;
        longint    nv;
        longint    g;
        longint    al;
        row     = row_of(w.lv);
        slot    = row * NUM_ACTIONS + (int'(w.act) % NUM_ACTIONS);
        r.act   = w.act;
        r.value = '0;
        case (w.op)
            OP_SELECT: begin
                nv      = row_peak(row, best);
                r.act   = t_action'(best);
                r.value = t_value'(nv);
            end
            OP_UPDATE: begin
                thr  = thr_m;
                qual = w.qual;
                g    = gamma_m;
                al   = alpha_m;
                if (qual >= thr) begin
                    reward = win_m;
                end else begin
                    // tenth of the shortfall, rounded half away from zero, minus the offset
                    reward = -((((thr - qual) * QUAL_TO_Q12) + TENTH_ROUND) / TENTH_DIV)
                             - longint'(pen_m);
                end
                nmax  = row_peak(row_of(w.next_lv), best);
                tgt   = reward + ((nmax * g + ROUND_HALF) >>> FRAC_SHIFT);
                cur   = q_mirror[slot];
                delta = tgt - cur;
                nv    = clip24(cur + ((delta * al + ROUND_HALF) >>> FRAC_SHIFT));
                q_mirror[slot] = t_value'(nv);
                r.value = t_value'(nv);
            end
            OP_WRITE: begin
                q_mirror[slot] = w.entry;
                r.value        = w.entry;
            end
            OP_READ: begin
                r.value = q_mirror[slot];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag(input string what, input logic signed [VALUE_W-1:0] want,
                        input logic signed [VALUE_W-1:0] got);
        err_count = err_count + 1;
        $display("%0t: %s differs: expected %0d actual %0d", $time, what, want, got);
    endtask

    // Monitor: checks result words, predicts on accepted request words, feeds the watchdog
    always @(posedge i_clk) begin : monitor
        rsp_word_t want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= req_bus.valid && req_bus.ready;
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (outcome_q.size() == 0) begin
                    err_count = err_count + 1;
                    $display("%0t: unexpected result word: action %0d value %0d", $time,
                             rsp_bus.chosen_action, rsp_bus.value);
                end else begin
                    want = outcome_q.pop_front();
                    if (want.act !== rsp_bus.chosen_action)
                        flag("chosen_action", want.act, rsp_bus.chosen_action);
                    if (want.value !== rsp_bus.value)
                        flag("value", want.value, rsp_bus.value);
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                outcome_q.insert(outcome_q.size(), qle_outcome(req_words.pop_front()));
                acc_total = acc_total + 1;
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    // Driver: holds a word until taken, then offers the next one or idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!(req_bus.valid && !in_fire)) begin
            // one drain: stop offering until every result word is back
            if (!pause_done && acc_total >= PAUSE_AT) begin
                pause_on   = 1'b1;
                pause_done = 1'b1;
            end
            if (pause_on && outcome_q.size() == 0) pause_on = 1'b0;
            if (req_words.size() != 0 && !pause_on
                && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                req_bus.valid        <= 1'b1;
                req_bus.op           <= req_words[0].op;
                req_bus.state_levels <= req_words[0].lv;
                req_bus.next_levels  <= req_words[0].next_lv;
                req_bus.action       <= req_words[0].act;
                req_bus.quality      <= req_words[0].qual;
                req_bus.entry_value  <= req_words[0].entry;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if (!hold_done && acc_total >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            REG_THRESHOLD:  thr_m   = data[QUALITY_W-1:0];
            REG_LEARN_RATE: alpha_m = data[15:0];
            REG_DISCOUNT:   gamma_m = data[15:0];
            REG_SUCCESS:    win_m   = t_value'(data);
            REG_PENALTY:    pen_m   = data[22:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic program_regs(input t_quality thr, input logic [15:0] al,
                                input logic [15:0] ga, input t_value win,
                                input logic [22:0] pen);
        cfg_write(REG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_write(REG_LEARN_RATE, CFG_DATA_W'(al));
        cfg_write(REG_DISCOUNT, CFG_DATA_W'(ga));
        cfg_write(REG_SUCCESS, win);
        cfg_write(REG_PENALTY, CFG_DATA_W'(pen));
    endtask

    // Wait until the engine is empty, so registers may change
    task automatic settle();
        while (req_words.size() != 0 || outcome_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_word(input t_op op, input t_levels lv, input t_levels nlv,
                             input t_action act, input t_quality qual, input t_value entry);
        req_word_t w;
        w.op      = op;
        w.lv      = lv;
        w.next_lv = nlv;
        w.act     = act;
        w.qual    = qual;
        w.entry   = entry;
        req_words.insert(req_words.size(), w);
    endtask

    // Mostly rows from a small pool so that selects and updates see written values
    function automatic t_levels pick_state();
        if ($urandom_range(99) < 80) return pool[$urandom_range(POOL_SIZE - 1)];
        return t_levels'($urandom());
    endfunction

    task automatic push_random();
        req_word_t w;
        int        pick;
        int        qv;
        pick = $urandom_range(99);
        if (pick < 25)      w.op = OP_SELECT;
        else if (pick < 60) w.op = OP_UPDATE;
        else if (pick < 75) w.op = OP_WRITE;
        else                w.op = OP_READ;
        w.lv      = pick_state();
        w.next_lv = pick_state();
        w.act     = t_action'($urandom_range(ACTION_MAX));
        // half the qualities sit right around the threshold
        if ($urandom_range(1) != 0) begin
            w.qual = t_quality'($urandom());
        end else begin
            qv = int'(thr_m) + int'($urandom_range(6)) - 3;
            if (qv < 0) qv = 0;
            if (qv > QUAL_MAX) qv = QUAL_MAX;
            w.qual = t_quality'(qv);
        end
        if ($urandom_range(1) != 0) w.entry = t_value'($urandom());
        else                        w.entry = t_value'(int'($urandom_range(131071)) - 65536);
        req_words.insert(req_words.size(), w);
    endtask

    task automatic run_stimulus();
        // directed words on reset register values
        push_word(OP_READ,   LV_ZERO,  LV_ZERO,  3'd0, 13'd0,    24'sd0);
        push_word(OP_SELECT, LV_ZERO,  LV_ZERO,  3'd5, 13'd0,    24'sd0);
        push_word(OP_WRITE,  LV_THREE, LV_ZERO,  3'd7, 13'd0,    V_MAX);
        push_word(OP_READ,   LV_TWOS,  LV_ZERO,  3'd7, 13'd0,    24'sd0);
        push_word(OP_SELECT, LV_THREE, LV_ZERO,  3'd0, 13'd0,    24'sd0);
        push_word(OP_WRITE,  LV_ONES,  LV_ZERO,  3'd2, 13'd0,    24'sd100);
        push_word(OP_WRITE,  LV_ONES,  LV_ZERO,  3'd5, 13'd0,    24'sd100);
        push_word(OP_SELECT, LV_ONES,  LV_ZERO,  3'd0, 13'd0,    24'sd0);
        push_word(OP_WRITE,  LV_ONES,  LV_ZERO,  3'd0, 13'd0,    V_MIN);
        push_word(OP_SELECT, LV_ONES,  LV_ZERO,  3'd7, 13'd0,    24'sd0);
        push_word(OP_UPDATE, LV_ZERO,  LV_ONES,  3'd3, 13'd4400, 24'sd0);
        push_word(OP_UPDATE, LV_ZERO,  LV_THREE, 3'd4, 13'd0,    24'sd0);
        push_word(OP_UPDATE, LV_ZERO,  LV_ZERO,  3'd1, 13'd8191, 24'sd0);
        push_word(OP_UPDATE, LV_ZERO,  LV_ZERO,  3'd6, 13'd4399, 24'sd0);
        push_word(OP_READ,   LV_ZERO,  LV_ZERO,  3'd3, 13'd0,    24'sd0);
        push_word(OP_SELECT, LV_ZERO,  LV_ZERO,  3'd0, 13'd0,    24'sd0);
        push_word(OP_UPDATE, LV_THREE, LV_THREE, 3'd7, 13'd0,    V_MAX);
        settle();

        // largest register values: both saturation limits
        program_regs(13'h1FFF, 16'hFFFF, 16'hFFFF, V_MAX, 23'h7FFFFF);
        push_word(OP_UPDATE, LV_THREE, LV_THREE, 3'd7, 13'h1FFF, 24'sd0);
        push_word(OP_UPDATE, LV_ONES,  LV_ZERO,  3'd0, 13'd0,    24'sd0);
        push_word(OP_READ,   LV_ONES,  LV_ZERO,  3'd0, 13'd0,    24'sd0);
        settle();

        // smallest register values
        program_regs(13'd0, 16'd0, 16'd0, V_MIN, 23'd0);
        push_word(OP_UPDATE, 18'h00002, LV_THREE, 3'd0, 13'd0, 24'sd0);
        push_word(OP_SELECT, 18'h00002, LV_ZERO,  3'd0, 13'd0, 24'sd0);
        settle();

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: program_regs(13'd4400, 16'd655, 16'd6554, 24'sd40960, 23'd8192);
                2: program_regs(13'h1FFF, 16'hFFFF, 16'hFFFF, V_MAX, 23'h7FFFFF);
                4: program_regs(13'd0, 16'd0, 16'd0, V_MIN, 23'd0);
                default: program_regs(t_quality'($urandom()), 16'($urandom()),
                                      16'($urandom()), t_value'($urandom()),
                                      23'($urandom()));
            endcase
            calm = (ph == 3);
            foreach (pool[k]) pool[k] = t_levels'($urandom());
            repeat (PHASE_ITEMS) push_random();
            settle();
        end
        calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        req_bus.valid        = 1'b0;
        req_bus.op           = OP_SELECT;
        req_bus.state_levels = '0;
        req_bus.next_levels  = '0;
        req_bus.action       = '0;
        req_bus.quality      = '0;
        req_bus.entry_value  = '0;
        rsp_bus.ready        = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            run_stimulus();
            begin
                while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
            end
        join_any
        disable fork;

        timed_out = (idle_cycles >= WATCHDOG_LIMIT);
        if (timed_out)
            $display("%0t: watchdog expired, %0d result words outstanding", $time,
                     outcome_q.size());
        if (timed_out || err_count != 0) begin
            $display("tabular_q_learning_engine: mismatch");
        end else begin
            $display("tabular_q_learning_engine: match");
        end
        $finish;
    end

endmodule
